// ===== src/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion on a given clock, disabled while reset is low.
`define HTS_ASSERT(lbl, ck, rst_n, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) prop) \
	else $error("hts assertion failed");

// Concurrent assertion on clk, disabled during arst_n.
`define HTS_CHECK(lbl, prop) `HTS_ASSERT(lbl, clk, arst_n, prop)

`endif

// ===== src/hts_pkg.sv =====
// Package with the types and constants of the triangle instance scatter.
`timescale 1ns / 1ps
package hts_pkg;

	localparam logic [31:0] SEED_STEP = 32'd3266489917;
	localparam logic [31:0] MIX_MUL1 = 32'h7feb352d;
	localparam logic [31:0] MIX_MUL2 = 32'h846ca68b;
	localparam int unsigned LANES = 7;
	localparam logic [24:0] ONE_Q24 = 25'd16777216;
	localparam logic [23:0] CURVE_OFFSET = 24'd1677722;
	localparam logic [15:0] HEIGHT_RESET = 16'd1550;
	localparam logic [24:0] HEIGHT_BASE_MUL = 25'd500;
	localparam logic [26:0] HEIGHT_VAR_MUL = 27'd1550;
	localparam logic [24:0] BH_BASE_RESET = 25'(HEIGHT_RESET * 500);
	localparam logic [26:0] BH_VAR_RESET = 27'(HEIGHT_RESET * 1550);
	localparam logic signed [34:0] POS_MAX = 35'sd2147483647;
	localparam logic signed [34:0] POS_MIN = -35'sd2147483648;

	typedef struct packed {
		logic signed [31:0] base_x;
		logic signed [31:0] base_y;
		logic signed [31:0] base_z;
		logic signed [31:0] edge1_x;
		logic signed [31:0] edge1_y;
		logic signed [31:0] edge1_z;
		logic signed [31:0] edge2_x;
		logic signed [31:0] edge2_y;
		logic signed [31:0] edge2_z;
	} geom_t;

endpackage

// ===== src/hts_mix.sv =====
// Two-stage avalanche hash lane returning the top 24 bits of the hash.
`timescale 1ns / 1ps
module hts_mix (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] seed,
	output logic [23:0] frac
);

	logic [31:0] x;
	logic [31:0] y;
	logic [31:0] z;
	logic [31:0] m1_s2;
	logic [31:0] m2_s3;

	assign x = seed ^ (seed >> 16);
	assign y = m1_s2 ^ (m1_s2 >> 15);
	assign z = m2_s3 ^ (m2_s3 >> 16);
	assign frac = z[31:8];

	always_ff @(posedge clk) begin
		if (en) begin
			m1_s2 <= x * hts_pkg::MIX_MUL1;
			m2_s3 <= y * hts_pkg::MIX_MUL2;
		end
	end

endmodule

// ===== src/hts_coord.sv =====
// One position coordinate: two weighted edge products, sum and saturation.
`timescale 1ns / 1ps
module hts_coord (
	input  logic               clk,
	input  logic               en,
	input  logic [24:0]        r1,
	input  logic [24:0]        r2,
	input  logic signed [31:0] b,
	input  logic signed [31:0] e1,
	input  logic signed [31:0] e2,
	output logic signed [31:0] pos
);

	logic signed [57:0] p1_s5;
	logic signed [57:0] p2_s5;
	logic signed [31:0] b_s5;
	logic signed [34:0] sum;

	assign sum = 35'(b_s5) + 35'($signed(p1_s5[57:24])) + 35'($signed(p2_s5[57:24]));

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s5 <= $signed({1'b0, r1}) * e1;
			p2_s5 <= $signed({1'b0, r2}) * e2;
			b_s5 <= b;
			if (sum > hts_pkg::POS_MAX) begin
				pos <= hts_pkg::POS_MAX[31:0];
			end else if (sum < hts_pkg::POS_MIN) begin
				pos <= hts_pkg::POS_MIN[31:0];
			end else begin
				pos <= sum[31:0];
			end
		end
	end

endmodule

// ===== src/hashed_triangle_instance_scatter.sv =====
// Top level of the hashed triangle instance scatter pipeline.
//
//  channel | handshake               | payload
//  in      | in_valid / in_stall     | base, edge1, edge2, triangle_seed, instance_number
//  out     | out_valid / out_stall   | pos_x/y/z, height, yaw_turns, tint, curve, phase
//  cfg     | cfg_we                  | cfg_wdata (base_height)
//
// Six register stages; one item per cycle while the output item is not stalled.
// The depth is set by the two hash multiplies and the weight multiplies.
// The whole pipeline holds while the output item is stalled; bubbles pass through.
// Reset clears the valid bits and sets base_height to 1550.
`timescale 1ns / 1ps
module hashed_triangle_instance_scatter (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] base_x,
	input  logic signed [31:0] base_y,
	input  logic signed [31:0] base_z,
	input  logic signed [31:0] edge1_x,
	input  logic signed [31:0] edge1_y,
	input  logic signed [31:0] edge1_z,
	input  logic signed [31:0] edge2_x,
	input  logic signed [31:0] edge2_y,
	input  logic signed [31:0] edge2_z,
	input  logic [31:0]        triangle_seed,
	input  logic [15:0]        instance_number,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic signed [31:0] pos_z,
	output logic [27:0]        height,
	output logic [23:0]        yaw_turns,
	output logic [23:0]        tint,
	output logic [23:0]        curve,
	output logic [23:0]        phase
);

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [24:0] bh_base_q;
	logic [26:0] bh_var_q;
	logic [31:0] sd_s1;
	hts_pkg::geom_t geo_in, geo_s1, geo_s2, geo_s3, geo_s4;
	logic [23:0] frac [hts_pkg::LANES];
	logic [24:0] wsum;
	logic fold;
	logic [24:0] r1_s4, r2_s4;
	logic [23:0] f3_s4, f4_s4, f5_s4, f6_s4, f7_s4;
	logic [50:0] hprod_s5;
	logic [23:0] curve_s5, yaw_s5, tint_s5, phase_s5;

	assign adv = !(v_s6 && out_stall);
	assign in_stall = !adv;
	assign out_valid = v_s6;

	assign geo_in = '{base_x, base_y, base_z, edge1_x, edge1_y, edge1_z,
		edge2_x, edge2_y, edge2_z};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			bh_base_q <= hts_pkg::BH_BASE_RESET;
			bh_var_q <= hts_pkg::BH_VAR_RESET;
		end else begin
			if (adv) begin
				v_s1 <= in_valid;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
				v_s6 <= v_s5;
			end
			if (cfg_we) begin
				bh_base_q <= {9'd0, cfg_wdata} * hts_pkg::HEIGHT_BASE_MUL;
				bh_var_q <= {11'd0, cfg_wdata} * hts_pkg::HEIGHT_VAR_MUL;
			end
		end
	end

	genvar g;
	generate
		for (g = 0; g < hts_pkg::LANES; g++) begin : g_lane
			hts_mix u_mix (
				.clk  (clk),
				.en   (adv),
				.seed (sd_s1 + 32'(g + 1)),
				.frac (frac[g])
			);
		end
	endgenerate

	assign wsum = {1'b0, frac[0]} + {1'b0, frac[1]};
	assign fold = wsum > hts_pkg::ONE_Q24;

	always_ff @(posedge clk) begin
		if (adv) begin
			sd_s1 <= triangle_seed + 32'({16'd0, instance_number} * hts_pkg::SEED_STEP);
			geo_s1 <= geo_in;
			geo_s2 <= geo_s1;
			geo_s3 <= geo_s2;
			geo_s4 <= geo_s3;
			r1_s4 <= fold ? hts_pkg::ONE_Q24 - {1'b0, frac[0]} : {1'b0, frac[0]};
			r2_s4 <= fold ? hts_pkg::ONE_Q24 - {1'b0, frac[1]} : {1'b0, frac[1]};
			f3_s4 <= frac[2];
			f4_s4 <= frac[3];
			f5_s4 <= frac[4];
			f6_s4 <= frac[5];
			f7_s4 <= frac[6];
			hprod_s5 <= {24'd0, bh_var_q} * {27'd0, f3_s4};
			curve_s5 <= hts_pkg::CURVE_OFFSET + 24'(({2'd0, f6_s4} * 26'd3) >> 2);
			yaw_s5 <= f4_s4;
			tint_s5 <= f5_s4;
			phase_s5 <= f7_s4;
			height <= 28'(bh_base_q) + 28'(hprod_s5[50:24]);
			curve <= curve_s5;
			yaw_turns <= yaw_s5;
			tint <= tint_s5;
			phase <= phase_s5;
		end
	end

	hts_coord u_cx (
		.clk (clk), .en (adv), .r1 (r1_s4), .r2 (r2_s4),
		.b (geo_s4.base_x), .e1 (geo_s4.edge1_x), .e2 (geo_s4.edge2_x), .pos (pos_x)
	);
	hts_coord u_cy (
		.clk (clk), .en (adv), .r1 (r1_s4), .r2 (r2_s4),
		.b (geo_s4.base_y), .e1 (geo_s4.edge1_y), .e2 (geo_s4.edge2_y), .pos (pos_y)
	);
	hts_coord u_cz (
		.clk (clk), .en (adv), .r1 (r1_s4), .r2 (r2_s4),
		.b (geo_s4.base_z), .e1 (geo_s4.edge1_z), .e2 (geo_s4.edge2_z), .pos (pos_z)
	);

endmodule

// ===== src/hts_checker.sv =====
// Port-level checker for the triangle instance scatter, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hts_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [27:0] height,
	input logic [23:0] curve,
	input logic [31:0] pos_x
);

	`HTS_CHECK(a_stall_cause, in_stall |-> (out_valid && out_stall))
	`HTS_CHECK(a_out_hold, (out_valid && out_stall) |=> out_valid)
	`HTS_CHECK(a_out_stable, (out_valid && out_stall) |=> ($stable(pos_x) && $stable(curve)))
	`HTS_CHECK(a_curve_min, out_valid |-> (curve >= 24'd1677722))
	`HTS_CHECK(a_height_max, out_valid |-> (height <= 28'd134348800))

endmodule

bind hashed_triangle_instance_scatter hts_checker u_hts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.height    (height),
	.curve     (curve),
	.pos_x     (pos_x)
);

// ===== bench/hts_checker.sv =====
// Checker that predicts every instance of the triangle instance scatter and compares the results.
`timescale 1ns / 1ps
module hts_scoreboard (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [15:0]        cfg_wdata,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [31:0] base_x,
	input  logic signed [31:0] base_y,
	input  logic signed [31:0] base_z,
	input  logic signed [31:0] edge1_x,
	input  logic signed [31:0] edge1_y,
	input  logic signed [31:0] edge1_z,
	input  logic signed [31:0] edge2_x,
	input  logic signed [31:0] edge2_y,
	input  logic signed [31:0] edge2_z,
	input  logic [31:0]        triangle_seed,
	input  logic [15:0]        instance_number,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [27:0]        height,
	input  logic [23:0]        yaw_turns,
	input  logic [23:0]        tint,
	input  logic [23:0]        curve,
	input  logic [23:0]        phase,
	output int                 fail_count,
	output int                 pending,
	output int                 seen
);

	typedef struct {
		logic signed [31:0] px, py, pz;
		logic [27:0] h;
		logic [23:0] yaw, tnt, crv, ph;
	} blade_t;

	blade_t blade_q[int];
	int wr_cnt, rd_cnt;
	logic [15:0] height_reg;

	function automatic logic [31:0] avalanche(input logic [31:0] v);
		v = v ^ (v >> 16);
		v = v * 32'h7feb352d;
		v = v ^ (v >> 15);
		v = v * 32'h846ca68b;
		v = v ^ (v >> 16);
		return v;
	endfunction

	function automatic logic [23:0] hfrac(input logic [31:0] s);
		logic [31:0] m;
		m = avalanche(s);
		return m[31:8];
	endfunction

	function automatic logic signed [31:0] place(input logic signed [31:0] b,
			input logic signed [31:0] a, input logic signed [31:0] c,
			input logic [24:0] w1, input logic [24:0] w2);
		longint p1, p2, s;
		p1 = (longint'(w1) * longint'(a)) >>> 24;
		p2 = (longint'(w2) * longint'(c)) >>> 24;
		s = longint'(b) + p1 + p2;
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		return s[31:0];
	endfunction

	function automatic blade_t scatter_blade();
		blade_t r;
		logic [31:0] sd;
		logic [24:0] w1, w2;
		logic [23:0] f3, f6;
		logic [63:0] fac, hp;
		sd = triangle_seed + 32'(instance_number) * 32'd3266489917;
		w1 = {1'b0, hfrac(sd + 1)};
		w2 = {1'b0, hfrac(sd + 2)};
		f3 = hfrac(sd + 3);
		f6 = hfrac(sd + 6);
		if (w1 + w2 > 25'd16777216) begin
			w1 = 25'd16777216 - w1;
			w2 = 25'd16777216 - w2;
		end
		r.px = place(base_x, edge1_x, edge2_x, w1, w2);
		r.py = place(base_y, edge1_y, edge2_y, w1, w2);
		r.pz = place(base_z, edge1_z, edge2_z, w1, w2);
		fac = 64'd500 * 64'd16777216 + 64'd1550 * 64'(f3);
		hp = (64'(height_reg) * fac) >> 24;
		r.h = hp[27:0];
		r.yaw = hfrac(sd + 4);
		r.tnt = hfrac(sd + 5);
		r.crv = 24'd1677722 + 24'((3 * 64'(f6)) >> 2);
		r.ph = hfrac(sd + 7);
		return r;
	endfunction

	task automatic cmp(input string name, input longint e, input longint a);
		if (e != a) begin
			$error("%s: expected %0d, got %0d", name, e, a);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		blade_t e;
		if (!arst_n) begin
			height_reg <= 16'd1550;
			fail_count = 0;
			seen = 0;
			wr_cnt = 0;
			rd_cnt = 0;
			blade_q.delete();
		end else begin
			if (in_valid && !in_stall) begin
				blade_q[wr_cnt] = scatter_blade();
				wr_cnt++;
			end
			if (out_valid && !out_stall) begin
				seen++;
				if (rd_cnt == wr_cnt) begin
					$error("unexpected result item");
					fail_count++;
				end else begin
					e = blade_q[rd_cnt];
					blade_q.delete(rd_cnt);
					rd_cnt++;
					cmp("pos_x", e.px, pos_x);
					cmp("pos_y", e.py, pos_y);
					cmp("pos_z", e.pz, pos_z);
					cmp("height", e.h, height);
					cmp("yaw_turns", e.yaw, yaw_turns);
					cmp("tint", e.tnt, tint);
					cmp("curve", e.crv, curve);
					cmp("phase", e.ph, phase);
				end
			end
			if (cfg_we) height_reg <= cfg_wdata;
		end
		pending = wr_cnt - rd_cnt;
	end
endmodule

// ===== bench/hashed_triangle_instance_scatter_tb.sv =====
// Top of the testbench: stimulus, idling phases and the verdict for the instance scatter.
`timescale 1ns / 1ps
module hashed_triangle_instance_scatter_tb;
	logic clk, arst_n, cfg_we, in_valid, in_stall, out_valid, out_stall;
	logic [15:0] cfg_wdata, instance_number;
	logic signed [31:0] base_x, base_y, base_z, edge1_x, edge1_y, edge1_z;
	logic signed [31:0] edge2_x, edge2_y, edge2_z, pos_x, pos_y, pos_z;
	logic [31:0] triangle_seed;
	logic [27:0] height;
	logic [23:0] yaw_turns, tint, curve, phase;
	int fail_count, pending, seen, idle_pct, stall_pct, hold_left, cycles, sent;
	logic hold_req;
	bit hold_done;

	hashed_triangle_instance_scatter u_top (.*);
	hts_scoreboard u_chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always_ff @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("** hashed_triangle_instance_scatter: FAILED **");
			$finish;
		end
	end

	always_ff @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			out_stall <= 1'b1;
			hold_left <= 59;
			hold_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	function automatic logic [31:0] pick32();
		unique case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'(int'($urandom_range(2000)) - 1000);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_tri(input logic [31:0] bx, by, bz, ax, ay, az, cx, cy, cz,
			input logic [31:0] sd, input logic [15:0] inst);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		base_x <= bx; base_y <= by; base_z <= bz;
		edge1_x <= ax; edge1_y <= ay; edge1_z <= az;
		edge2_x <= cx; edge2_y <= cy; edge2_z <= cz;
		triangle_seed <= sd;
		instance_number <= inst;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sent++;
	endtask

	task automatic send_random();
		send_tri(pick32(), pick32(), pick32(), pick32(), pick32(), pick32(),
			pick32(), pick32(), pick32(), $urandom, 16'($urandom));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_height(input logic [15:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		logic [15:0] heights[4];
		sent = 0; idle_pct = 0; stall_pct = 0; hold_req = 1'b0;
		arst_n = 0; cfg_we = 0; cfg_wdata = 0; in_valid = 0;
		{base_x, base_y, base_z, edge1_x, edge1_y, edge1_z} = '0;
		{edge2_x, edge2_y, edge2_z, triangle_seed, instance_number} = '0;
		heights = '{16'd0, 16'hffff, 16'd1550, 16'd777};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16'd0);
		send_tri(32'h7fffffff, 32'h80000000, 0, 32'h7fffffff, 32'h80000000,
			32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'hffffffff, 16'hffff);
		send_tri(32'h80000000, 32'h7fffffff, 5, 32'h80000000, 32'h7fffffff, 32'hffffffff,
			32'h80000000, 32'h7fffffff, 1, 32'h12345678, 16'h8000);
		for (int i = 0; i < 16; i++)
			send_tri(1000, -1000, 0, 4096, -4096, 4096, -4096, 4096, 4096, i, 16'(i));
		drain();
		for (int p = 0; p < 4; p++) begin
			set_height(heights[p]);
			idle_pct = (p == 1 || p == 3) ? 45 : 0;
			idle_pct = (p == 3) ? 12 : idle_pct;
			stall_pct = (p == 2) ? 45 : (p == 3 ? 12 : 0);
			for (int i = 0; i < 95; i++) begin
				if (p == 0 && i == 20) hold_req <= 1'b1;
				send_random();
			end
			drain();
		end
		stall_pct = 0;
		$display("Covered %0d triangles over four base heights, extreme coordinates,",
			sent);
		$display("saturating positions, idle and stall phases and a long output hold.");
		if (fail_count == 0 && seen == sent)
			$display("** hashed_triangle_instance_scatter: PASSED **");
		else
			$display("** hashed_triangle_instance_scatter: FAILED **");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+src
src/hts_pkg.sv
src/hts_mix.sv
src/hts_coord.sv
src/hashed_triangle_instance_scatter.sv
src/hts_checker.sv
bench/hts_checker.sv
bench/hashed_triangle_instance_scatter_tb.sv
